// File: design/charge_port_meter_controller_macros.svh
// Assertion helpers for the checker file.
`ifndef CHARGE_PORT_METER_CONTROLLER_MACROS_SVH
`define CHARGE_PORT_METER_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, idle in reset.
`define CPMC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("charge port meter controller: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, idle in reset.
`define CPMC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("charge port meter controller: next-cycle check failed");

`endif

// File: design/cpmc_pkg.sv
package cpmc_pkg;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PULSE = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // Result events
    localparam logic [1:0] EVT_NONE    = 2'd0;
    localparam logic [1:0] EVT_STARTED = 2'd1;
    localparam logic [1:0] EVT_STOPPED = 2'd2;
    localparam logic [1:0] EVT_REPORT  = 2'd3;

    // Stop reasons
    localparam logic [1:0] RSN_NONE   = 2'd0;
    localparam logic [1:0] RSN_ENERGY = 2'd1;
    localparam logic [1:0] RSN_TIME   = 2'd2;
    localparam logic [1:0] RSN_USER   = 2'd3;

    // Session kinds
    localparam logic [1:0] KIND_IDLE    = 2'd0;
    localparam logic [1:0] KIND_PREPAID = 2'd1;
    localparam logic [1:0] KIND_ACCOUNT = 2'd2;

    // Requested session kind on start
    localparam logic START_PREPAID = 1'b0;

    // Pulse class flags
    localparam logic [1:0] FLAG_NORMAL   = 2'd0;
    localparam logic [1:0] FLAG_OVERLOAD = 2'd1;
    localparam logic [1:0] FLAG_FULL     = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLOAD_GAP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLOAD_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_GAP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_COIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_COIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_EVERY   = 3'd6;

    typedef struct packed {
        logic        relay_on;
        logic [1:0]  event_res;
        logic [1:0]  stop_reason;
        logic [1:0]  pulse_flag;
        logic [23:0] consumed;
        logic [1:0]  active_kind;
        logic        final_report;
    } t_result;

endpackage

// File: design/cpmc_core.sv
module cpmc_core
    import cpmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_command,
    input  logic                 i_session_kind,
    input  logic [7:0]           i_coin_count,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_result              o_result
);

    // Configuration
    logic [15:0] r_ovl_gap;
    logic [7:0]  r_ovl_limit;
    logic [31:0] r_full_gap;
    logic [7:0]  r_full_limit;
    logic [15:0] r_ppc;
    logic [23:0] r_ms_per_coin;
    logic [7:0]  r_report_every;

    // Session and pulse-gap state
    logic [1:0]  r_kind,  n_kind;
    logic [7:0]  r_coins, n_coins;
    logic [23:0] r_total, n_total;
    logic [7:0]  r_fast,  n_fast;
    logic [7:0]  r_slow,  n_slow;
    logic [31:0] r_since, n_since;
    logic [31:0] r_left,  n_left;
    logic [7:0]  r_rpt,   n_rpt;
    logic [1:0]  r_flag,  n_flag;

    logic [1:0]  evt;
    logic [1:0]  reason;
    logic [7:0]  fast_inc;
    logic [7:0]  slow_inc;
    logic [23:0] total_inc;
    logic [7:0]  rpt_inc;
    logic [31:0] left_dec;
    logic [23:0] paid_pulses;
    logic [31:0] paid_ms;

    assign fast_inc    = (r_fast != 8'hFF) ? r_fast + 8'd1 : r_fast;
    assign slow_inc    = (r_slow != 8'hFF) ? r_slow + 8'd1 : r_slow;
    assign total_inc   = (r_total != 24'hFF_FFFF) ? r_total + 24'd1 : r_total;
    assign rpt_inc     = (r_rpt != 8'hFF) ? r_rpt + 8'd1 : r_rpt;
    assign left_dec    = r_left - 32'd1;
    assign paid_pulses = 24'(r_coins) * 24'(r_ppc);
    assign paid_ms     = 32'(i_coin_count) * 32'(r_ms_per_coin);

    always_comb begin
        n_kind  = r_kind;
        n_coins = r_coins;
        n_total = r_total;
        n_fast  = r_fast;
        n_slow  = r_slow;
        n_since = r_since;
        n_left  = r_left;
        n_rpt   = r_rpt;
        n_flag  = r_flag;
        evt     = EVT_NONE;
        reason  = RSN_NONE;

        case (i_command)
            CMD_TICK: begin
                if (r_since != 32'hFFFF_FFFF) begin
                    n_since = r_since + 32'd1;
                end
                if (r_kind == KIND_PREPAID && r_left != 32'd0) begin
                    n_left = left_dec;
                    if (left_dec == 32'd0) begin
                        evt    = EVT_STOPPED;
                        reason = RSN_TIME;
                    end
                end
            end
            CMD_PULSE: begin
                // class the gap; a counter that passes its limit fires and clears
                if (r_since < {16'd0, r_ovl_gap}) begin
                    n_fast = fast_inc;
                    if (fast_inc > r_ovl_limit) begin
                        n_flag = FLAG_OVERLOAD;
                        n_fast = 8'd0;
                    end
                end else if (r_since > r_full_gap) begin
                    n_slow = slow_inc;
                    if (slow_inc > r_full_limit) begin
                        n_flag = FLAG_FULL;
                        n_slow = 8'd0;
                    end
                end else begin
                    n_fast = 8'd0;
                    n_slow = 8'd0;
                end
                n_since = 32'd0;

                if (r_kind == KIND_PREPAID) begin
                    n_total = total_inc;
                    if (total_inc >= paid_pulses) begin
                        evt    = EVT_STOPPED;
                        reason = RSN_ENERGY;
                    end
                end else if (r_kind == KIND_ACCOUNT) begin
                    n_total = total_inc;
                    n_rpt   = rpt_inc;
                    if (rpt_inc >= r_report_every) begin
                        n_rpt = 8'd0;
                        evt   = EVT_REPORT;
                    end
                end
            end
            CMD_START: begin
                n_coins = 8'd0;
                n_total = 24'd0;
                n_left  = 32'd0;
                n_rpt   = 8'd0;
                n_flag  = FLAG_NORMAL;
                if (i_session_kind == START_PREPAID) begin
                    n_kind  = KIND_PREPAID;
                    n_coins = i_coin_count;
                    n_left  = paid_ms;
                end else begin
                    n_kind = KIND_ACCOUNT;
                end
                evt = EVT_STARTED;
            end
            CMD_STOP: begin
                if (r_kind != KIND_IDLE) begin
                    evt    = EVT_STOPPED;
                    reason = RSN_USER;
                end
            end
            default: begin
                evt = EVT_NONE;
            end
        endcase

        o_result.relay_on     = (n_kind != KIND_IDLE);
        o_result.event_res    = evt;
        o_result.stop_reason  = RSN_NONE;
        o_result.pulse_flag   = n_flag;
        o_result.consumed     = n_total;
        o_result.active_kind  = n_kind;
        o_result.final_report = 1'b0;

        if (evt == EVT_STOPPED) begin
            o_result.relay_on     = 1'b0;
            o_result.stop_reason  = reason;
            o_result.active_kind  = KIND_IDLE;
            o_result.final_report = (r_kind == KIND_ACCOUNT);
            // drop the session once its totals are reported; gap tracking stays
            n_kind  = KIND_IDLE;
            n_coins = 8'd0;
            n_total = 24'd0;
            n_left  = 32'd0;
            n_rpt   = 8'd0;
            n_flag  = FLAG_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovl_gap      <= 16'd100;
            r_ovl_limit    <= 8'd5;
            r_full_gap     <= 32'd60000;
            r_full_limit   <= 8'd5;
            r_ppc          <= 16'd100;
            r_ms_per_coin  <= 24'd3600000;
            r_report_every <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OVERLOAD_GAP:    r_ovl_gap      <= i_cfg_data[15:0];
                CFG_OVERLOAD_LIMIT:  r_ovl_limit    <= i_cfg_data[7:0];
                CFG_FULL_GAP:        r_full_gap     <= i_cfg_data[31:0];
                CFG_FULL_LIMIT:      r_full_limit   <= i_cfg_data[7:0];
                CFG_PULSES_PER_COIN: r_ppc          <= i_cfg_data[15:0];
                CFG_MS_PER_COIN:     r_ms_per_coin  <= i_cfg_data[23:0];
                CFG_REPORT_EVERY:    r_report_every <= i_cfg_data[7:0];
                default: begin
                    r_ovl_gap <= r_ovl_gap;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_IDLE;
            r_coins <= 8'd0;
            r_total <= 24'd0;
            r_fast  <= 8'd0;
            r_slow  <= 8'd0;
            r_since <= 32'd0;
            r_left  <= 32'd0;
            r_rpt   <= 8'd0;
            r_flag  <= FLAG_NORMAL;
        end else if (i_accept) begin
            r_kind  <= n_kind;
            r_coins <= n_coins;
            r_total <= n_total;
            r_fast  <= n_fast;
            r_slow  <= n_slow;
            r_since <= n_since;
            r_left  <= n_left;
            r_rpt   <= n_rpt;
            r_flag  <= n_flag;
        end
    end

endmodule

// File: design/charge_port_meter_controller.sv
// Charging-port meter controller: drives one charging relay from millisecond
// ticks, meter pulses and start/stop commands.
// Input channel (i_in_valid / o_in_ready) carries one command word; output
// channel (o_out_valid / i_out_ready) returns exactly one result word per
// command, in order. Configuration is a plain write port (i_cfg_we,
// i_cfg_index, i_cfg_data), to be written only while no command is in
// flight; the block does not enforce this. A result is registered when its
// command is accepted. Throughput: one command per cycle while o_in_ready
// is high; the session update and the coin multiplies are combinational
// logic ahead of the session registers, so no loop limits the rate.
// The result side is a two-word buffer: a stalled receiver holds the head
// word and one more command is still taken into the spare slot; o_in_ready
// drops only once both slots are full, and rises as soon as one drains.
// Synchronous reset (i_rst_n low) loads the default configuration, ends any
// session, clears the pulse-gap counters and flushes the result buffer.
module charge_port_meter_controller
    import cpmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_command,
    input  logic                  i_session_kind,
    input  logic [7:0]            i_coin_count,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_relay_on,
    output logic [1:0]            o_event_res,
    output logic [1:0]            o_stop_reason,
    output logic [1:0]            o_pulse_flag,
    output logic [23:0]           o_consumed,
    output logic [1:0]            o_active_kind,
    output logic                  o_final_report,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    push;
    logic    pop;
    t_result step_res;
    t_result r_head;
    t_result r_skid;
    logic    r_head_valid;
    logic    r_skid_valid;

    assign o_in_ready = !r_skid_valid;
    assign push       = i_in_valid && o_in_ready;
    assign pop        = r_head_valid && i_out_ready;

    cpmc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (push),
        .i_command      (i_command),
        .i_session_kind (i_session_kind),
        .i_coin_count   (i_coin_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            // advance: the spare word moves up, or the fresh word takes the head
            if (r_skid_valid) begin
                r_head_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_head_valid <= push;
            end
        end else if (push) begin
            if (r_head_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_head_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_head <= r_skid;
        end else if (push && (pop || !r_head_valid)) begin
            r_head <= step_res;
        end
        if (push && r_head_valid && !pop) begin
            r_skid <= step_res;
        end
    end

    assign o_out_valid    = r_head_valid;
    assign o_relay_on     = r_head.relay_on;
    assign o_event_res    = r_head.event_res;
    assign o_stop_reason  = r_head.stop_reason;
    assign o_pulse_flag   = r_head.pulse_flag;
    assign o_consumed     = r_head.consumed;
    assign o_active_kind  = r_head.active_kind;
    assign o_final_report = r_head.final_report;

endmodule

// File: design/cpmc_checker.sv
`include "charge_port_meter_controller_macros.svh"

module cpmc_checker
    import cpmc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [1:0]            i_command,
    input logic                  i_session_kind,
    input logic [7:0]            i_coin_count,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_relay_on,
    input logic [1:0]            o_event_res,
    input logic [1:0]            o_stop_reason,
    input logic [1:0]            o_pulse_flag,
    input logic [23:0]           o_consumed,
    input logic [1:0]            o_active_kind,
    input logic                  o_final_report,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // a stalled result word must hold
    `CPMC_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_consumed) && $stable(o_event_res) && $stable(o_active_kind))

    // a stop opens the relay and leaves the port idle
    `CPMC_ASSERT_IMP(a_stop_idle, o_out_valid && o_event_res == EVT_STOPPED, !o_relay_on && o_active_kind == KIND_IDLE)

    // a final report only comes with a stop
    `CPMC_ASSERT_IMP(a_final_on_stop, o_out_valid && o_final_report, o_event_res == EVT_STOPPED)

    // a stop reason only comes with a stop
    `CPMC_ASSERT_IMP(a_reason_on_stop, o_out_valid && o_event_res != EVT_STOPPED, o_stop_reason == RSN_NONE)

    // the relay is closed exactly while a session runs
    `CPMC_ASSERT_IMP(a_relay_session, o_out_valid, o_relay_on == (o_active_kind != KIND_IDLE))

endmodule

bind charge_port_meter_controller cpmc_checker u_cpmc_checker (.*);
